FILE: design/rmet_pkg.sv
// Shared constants and types for the rational map escape-time block.
`timescale 1ns / 1ps

package rmet_pkg;

    // Fixed-point format of z, k and the point
    localparam int FRAC_BITS = 24;
    localparam int VAL_W     = 32;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 36;
    localparam int PROD_W = 2 * MUL_W;

    // Intermediate widths (bounded by the escape test |z|^2 <= 256)
    localparam int ZSQ_W  = 34;
    localparam int DEN_W  = 35;
    localparam int DM_W   = 48;
    localparam int Q_W    = 41;
    localparam int QS_W   = 42;
    localparam int SUM_W  = 43;
    localparam int CNT_W  = 16;
    localparam int BIT_W  = 7;

    // Escape threshold 256.0 at 2*FRAC_BITS fractional bits
    localparam logic [63:0] ESC_LIMIT = 64'd256 << (2 * FRAC_BITS);
    localparam logic [DEN_W-1:0] ONE_VAL = DEN_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0] Q_SAT = Q_W'(1) << (Q_W - 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_ITER   = 2'd0;
    localparam logic [1:0] CFG_JULIA_MODE = 2'd1;
    localparam logic [1:0] CFG_JULIA_RE   = 2'd2;
    localparam logic [1:0] CFG_JULIA_IM   = 2'd3;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [CNT_W-1:0] count_t;

endpackage

FILE: design/rational_map_escape_time.sv
// Escape-time counter for z <- z^2/(1+z^2) + k on a shared multiplier and divider.
// Each update is one check step, ten multiplier steps, two bit-serial divisions
// and two add steps.
// Throughput: one point at a time; an output register frees the input while a result waits.
// Reset: async active low; max_iter returns to 256, Julia mode and constant to zero.
`timescale 1ns / 1ps

module rational_map_escape_time
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rmet_pkg::val_t       point_re,
    input  rmet_pkg::val_t       point_im,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rmet_pkg::count_t     iter_count,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import rmet_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(PROD_W - 1);

    logic [2:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;

    count_t      max_iter_reg;
    logic        julia_mode_reg;
    val_t        julia_re_reg, julia_im_reg;

    val_t        x_reg, x_next, y_reg, y_next, kr_reg, ki_reg;
    count_t      iter_reg, iter_next, result_reg, result_next;
    logic        out_valid_reg, out_valid_next;
    count_t      out_count_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic [63:0]              xx_reg, xx_next;
    logic signed [ZSQ_W-1:0]  zr_reg, zr_next, zi_reg, zi_next;
    logic [DM_W-1:0]          dm_reg, dm_next;
    logic signed [PROD_W-1:0] nr_reg, nr_next, ni_reg, ni_next;

    logic [PROD_W-1:0]        num_reg, num_next;
    logic [DM_W-1:0]          rem_reg, rem_next;
    logic [Q_W-1:0]           q_reg, q_next;
    logic                     sat_reg, sat_next, neg_reg, neg_next;
    logic                     sel_reg, sel_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;

    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [DEN_W-1:0]  dr;
    logic [63:0]              mag;
    logic signed [63:0]       sq_diff;
    logic signed [PROD_W-1:0] dm_sum;
    logic [DM_W:0]            rem_sh;
    logic                     rem_ge;
    logic [Q_W-1:0]           q_eff;
    logic signed [QS_W-1:0]   q_signed;
    logic signed [SUM_W-1:0]  k_sel, q_sum;
    val_t                     q_sat;
    logic signed [PROD_W-1:0] div_src;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= count_t'(256);
            julia_mode_reg <= 1'b0;
            julia_re_reg   <= '0;
            julia_im_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ITER:   max_iter_reg   <= cfg_data[CNT_W-1:0];
                CFG_JULIA_MODE: julia_mode_reg <= cfg_data[0];
                CFG_JULIA_RE:   julia_re_reg   <= cfg_data;
                CFG_JULIA_IM:   julia_im_reg   <= cfg_data;
            endcase
        end
    end

    // Denominator real part and operand select for the shared multiplier
    assign dr = DEN_W'(zr_reg) + $signed(ONE_VAL);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            4'd0:    begin op_a = MUL_W'(x_reg);  op_b = MUL_W'(x_reg);  end
            4'd1:    begin op_a = MUL_W'(y_reg);  op_b = MUL_W'(y_reg);  end
            4'd2:    begin op_a = MUL_W'(x_reg);  op_b = MUL_W'(y_reg);  end
            4'd3:    begin op_a = MUL_W'(dr);     op_b = MUL_W'(dr);     end
            4'd4:    begin op_a = MUL_W'(zi_reg); op_b = MUL_W'(zi_reg); end
            4'd5:    begin op_a = MUL_W'(zr_reg); op_b = MUL_W'(dr);     end
            4'd6:    begin op_a = MUL_W'(zi_reg); op_b = MUL_W'(zi_reg); end
            4'd7:    begin op_a = MUL_W'(zi_reg); op_b = MUL_W'(dr);     end
            4'd8:    begin op_a = MUL_W'(zr_reg); op_b = MUL_W'(zi_reg); end
            default: begin op_a = '0;             op_b = '0;             end
        endcase
    end

    // Register every product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Escape test, z^2 and denominator magnitude
    assign mag     = xx_reg + prod_reg[63:0];
    assign sq_diff = $signed(xx_reg) - $signed(prod_reg[63:0]);
    assign dm_sum  = acc_reg + prod_reg;

    // One restoring division step
    assign rem_sh = {rem_reg, num_reg[PROD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dm_reg};

    // Saturate the quotient, apply sign, add k, saturate to 32 bits
    assign q_eff    = (sat_reg || q_reg > Q_SAT) ? Q_SAT : q_reg;
    assign q_signed = neg_reg ? -$signed({1'b0, q_eff}) : $signed({1'b0, q_eff});
    assign k_sel    = sel_reg ? SUM_W'(ki_reg) : SUM_W'(kr_reg);
    assign q_sum    = SUM_W'(q_signed) + k_sel;
    always_comb
    begin
        priority if (q_sum > SUM_W'(32'sh7FFF_FFFF))
            q_sat = 32'sh7FFF_FFFF;
        else if (q_sum < -SUM_W'(64'sh8000_0000))
            q_sat = 32'sh8000_0000;
        else
            q_sat = q_sum[VAL_W-1:0];
    end

    assign div_src = sel_next ? ni_reg : nr_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        iter_next      = iter_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        xx_next        = xx_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        dm_next        = dm_reg;
        nr_next        = nr_reg;
        ni_next        = ni_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        neg_next       = neg_reg;
        sel_next       = sel_reg;
        bit_next       = bit_reg;

        // drop the result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = julia_mode_reg ? point_re : '0;
                    y_next     = julia_mode_reg ? point_im : '0;
                    iter_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next = '0;
                if (iter_reg >= max_iter_reg)
                begin
                    result_next = max_iter_reg;
                    state_next  = S_FIN;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    4'd1: xx_next = prod_reg[63:0];
                    4'd2:
                    begin
                        zr_next = ZSQ_W'(sq_diff >>> FRAC_BITS);
                        if (mag > ESC_LIMIT)
                        begin
                            result_next = iter_reg;
                            state_next  = S_FIN;
                        end
                    end
                    4'd3: zi_next  = ZSQ_W'(prod_reg >>> (FRAC_BITS - 1));
                    4'd4: acc_next = prod_reg;
                    4'd5:
                    begin
                        dm_next = dm_sum[FRAC_BITS +: DM_W];
                        if (dm_sum[FRAC_BITS +: DM_W] == '0)
                            dm_next = DM_W'(1);
                    end
                    4'd6: acc_next = prod_reg;
                    4'd7: nr_next  = dm_sum;
                    4'd8: acc_next = prod_reg;
                    4'd9:
                    begin
                        ni_next    = acc_reg - prod_reg;
                        sel_next   = 1'b0;
                        neg_next   = nr_reg[PROD_W-1];
                        num_next   = nr_reg[PROD_W-1] ? PROD_W'(-nr_reg) : nr_reg;
                        rem_next   = '0;
                        q_next     = '0;
                        sat_next   = 1'b0;
                        bit_next   = '0;
                        state_next = S_DIV;
                    end
                    default: ;
                endcase
            end
            S_DIV:
            begin
                // advance one quotient bit
                num_next = {num_reg[PROD_W-2:0], 1'b0};
                rem_next = rem_ge ? DM_W'(rem_sh - {1'b0, dm_reg}) : rem_sh[DM_W-1:0];
                if (q_reg >= Q_SAT)
                    sat_next = 1'b1;
                else
                    q_next = {q_reg[Q_W-2:0], rem_ge};
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == LAST_BIT)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                if (sel_reg)
                begin
                    y_next     = q_sat;
                    iter_next  = iter_reg + count_t'(1);
                    state_next = S_CHECK;
                end
                else
                begin
                    x_next     = q_sat;
                    sel_next   = 1'b1;
                    neg_next   = div_src[PROD_W-1];
                    num_next   = div_src[PROD_W-1] ? PROD_W'(-div_src) : div_src;
                    rem_next   = '0;
                    q_next     = '0;
                    sat_next   = 1'b0;
                    bit_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        iter_reg   <= iter_next;
        result_reg <= result_next;
        acc_reg    <= acc_next;
        xx_reg     <= xx_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        dm_reg     <= dm_next;
        nr_reg     <= nr_next;
        ni_reg     <= ni_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        sat_reg    <= sat_next;
        neg_reg    <= neg_next;
        sel_reg    <= sel_next;
        bit_reg    <= bit_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            kr_reg <= julia_mode_reg ? julia_re_reg : point_re;
            ki_reg <= julia_mode_reg ? julia_im_reg : point_im;
        end
        if (state_reg == S_FIN && (!out_valid_reg || !out_stall))
            out_count_reg <= result_reg;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign iter_count = out_count_reg;

`ifndef SYNTHESIS
    // An item is taken only in the idle state
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("item accepted outside idle");

    // Divisor never zero while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dm_reg != '0))
        else $error("zero divisor");

    // Iteration count stays within the limit while working
    a_iter_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_DIV) |-> (iter_reg < max_iter_reg))
        else $error("iteration past limit");

    // A new result is never above the limit
    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_count_reg <= max_iter_reg))
        else $error("result above limit");
`endif

endmodule
